### hw/rtl/dfabm_pkg.sv
// Shared types and constants of the byte-driven DFA matcher.
package dfabm_pkg;

   localparam int NODE_COUNT      = 1024;
   localparam int NODE_BITS       = $clog2(NODE_COUNT);
   localparam int SYMBOL_BITS     = 8;
   localparam int TRANS_DEPTH     = NODE_COUNT * (2 ** SYMBOL_BITS);
   localparam int TRANS_ADDR_BITS = NODE_BITS + SYMBOL_BITS;
   localparam int TAG_BITS        = 32;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_BITS      = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS      = $clog2(QUEUE_DEPTH + 1);

   typedef logic [NODE_BITS-1:0]       node_type;
   typedef logic [SYMBOL_BITS-1:0]     symbol_type;
   typedef logic [TAG_BITS-1:0]        tag_type;
   typedef logic [TRANS_ADDR_BITS-1:0] trans_addr_type;

   localparam node_type DEAD_NODE   = node_type'(0);
   localparam node_type START_RESET = node_type'(1);

   typedef enum logic [1:0] {
      OP_WRITE_EDGE = 2'd0,
      OP_WRITE_NODE = 2'd1,
      OP_RESTART    = 2'd2,
      OP_DATA       = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_MORE   = 2'd0,
      ST_ACCEPT = 2'd1,
      ST_REJECT = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type opcode;
      node_type   node;
      symbol_type symbol;
      node_type   target;
      logic       accepting;
      tag_type    tag;
      logic       last;
   } req_type;

   typedef struct packed {
      status_type status;
      tag_type    match_tag;
   } rsp_type;

   // Sweep that zeroes the transition and flag stores after reset.
   typedef struct packed {
      logic           busy;
      trans_addr_type addr;
   } clear_type;

   // A byte walk that ends in a result: the node reached and whether it is dead.
   typedef struct packed {
      logic     valid;
      node_type node;
      logic     dead;
   } lookup_type;

endpackage

### hw/rtl/dfa_byte_matcher_unit.sv
// Top level of the table-driven byte DFA matcher.
//
// The matcher walks a deterministic automaton of 1024 nodes over a byte
// stream, one request per clock cycle while req_ready is high: each data byte
// reads the next node from a 256K-entry transition RAM, and the RAM's read
// data feeds straight back as the address of the following byte, so that
// single RAM read loop sets the rate of one byte per cycle when not stalled.
// Load requests (transition entries, node flag and tag) and restart requests
// also pass without holding up the next one. After reset the block clears the
// transition store and the accepting flags in one pass, during which req_ready
// stays low; the start register can be written at any time. A data byte that
// ends a chunk, or that reaches the dead node, gives its response through the
// s1 and s2 registers and a four-entry response queue, so a stalled consumer
// does not hold up requests until that queue and the results still being
// formed fill it. Reaching the dead node reports reject once and mutes the
// rest of the chunk; a restart request loads the start node and ends any
// mute. Node 0 is the dead node and loads that name it are dropped.
module dfa_byte_matcher_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  dfabm_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output dfabm_pkg::rsp_type rsp_payload,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  dfabm_pkg::node_type csr_wdata
);
   import dfabm_pkg::*;

   node_type   start_ff;
   node_type   start_in;
   clear_type  clear;
   lookup_type lookup;
   logic       room;
   logic       req_fire;

   // The start register takes every write; it needs no flow control.
   assign csr_ready = 1'b1;
   assign start_in  = (csr_valid && csr_ready) ? csr_wdata : start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= START_RESET;
      end else begin
         start_ff <= start_in;
      end
   end

   // Requests wait while the clear pass runs or the response queue is spoken for.
   assign req_ready = !clear.busy && room;
   assign req_fire  = req_valid && req_ready;

   dfabm_clear u_clear (
      .clock (clock),
      .reset (reset),
      .clear (clear)
   );

   dfabm_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .clear       (clear),
      .req_fire    (req_fire),
      .req_payload (req_payload),
      .start_state (start_ff),
      .lookup      (lookup)
   );

   dfabm_resolve u_resolve (
      .clock       (clock),
      .reset       (reset),
      .clear       (clear),
      .req_fire    (req_fire),
      .req_payload (req_payload),
      .lookup      (lookup),
      .room        (room),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### hw/rtl/dfabm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dfabm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // A read of the address written in the same cycle returns the old contents.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### hw/rtl/dfabm_clear.sv
// Post-reset sweep that walks every transition address once.
module dfabm_clear (
   input  logic                 clock,
   input  logic                 reset,
   output dfabm_pkg::clear_type clear
);
   import dfabm_pkg::*;

   logic           busy_ff, busy_in;
   trans_addr_type addr_ff, addr_in;

   always_comb begin
      busy_in = busy_ff;
      addr_in = addr_ff;
      if (busy_ff) begin
         addr_in = addr_ff + trans_addr_type'(1);
         if (addr_ff == {TRANS_ADDR_BITS{1'b1}}) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         addr_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         addr_ff <= addr_in;
      end
   end

   assign clear.busy = busy_ff;
   assign clear.addr = addr_ff;

   a_clear_ends_at_top: assert property (@(posedge clock) disable iff (reset)
      $fell(busy_ff) |-> ($past(addr_ff) == {TRANS_ADDR_BITS{1'b1}}))
      else $error("clear sweep stopped before the last address");

endmodule

### hw/rtl/dfabm_walk.sv
// Transition store and the per-byte state walk with its chunk mute.
module dfabm_walk (
   input  logic                  clock,
   input  logic                  reset,
   input  dfabm_pkg::clear_type  clear,
   input  logic                  req_fire,
   input  dfabm_pkg::req_type    req_payload,
   input  dfabm_pkg::node_type   start_state,
   output dfabm_pkg::lookup_type lookup
);
   import dfabm_pkg::*;

   node_type       cur_ff, cur_in;
   logic           muted_ff, muted_in;
   logic           s1_valid_ff, s1_valid_in;
   logic           s1_live_ff, s1_live_in;
   logic           s1_last_ff, s1_last_in;
   node_type       trans_rdata;
   node_type       next_node;
   node_type       eff_cur;
   logic           eff_muted;
   logic           trans_we;
   trans_addr_type trans_waddr;
   node_type       trans_wdata;
   trans_addr_type trans_raddr;

   // Write port: the clear sweep owns it until done, then edge loads use it.
   always_comb begin
      if (clear.busy) begin
         trans_we    = 1'b1;
         trans_waddr = clear.addr;
         trans_wdata = DEAD_NODE;
      end else begin
         trans_we    = req_fire && (req_payload.opcode == OP_WRITE_EDGE)
                       && (req_payload.node != DEAD_NODE);
         trans_waddr = {req_payload.node, req_payload.symbol};
         trans_wdata = req_payload.target;
      end
   end

   assign trans_raddr = {eff_cur, req_payload.symbol};

   dfabm_ram #(
      .WIDTH (NODE_BITS),
      .DEPTH (TRANS_DEPTH)
   ) u_trans_ram (
      .clock (clock),
      .we    (trans_we),
      .waddr (trans_waddr),
      .wdata (trans_wdata),
      .raddr (trans_raddr),
      .rdata (trans_rdata)
   );

   always_comb begin
      // The byte looked up last cycle resolves now; its node feeds the next address.
      next_node = s1_live_ff ? trans_rdata : DEAD_NODE;
      if (s1_valid_ff) begin
         eff_cur   = next_node;
         eff_muted = (next_node == DEAD_NODE) && !s1_last_ff;
      end else begin
         eff_cur   = cur_ff;
         eff_muted = muted_ff;
      end

      lookup.valid = s1_valid_ff && ((next_node == DEAD_NODE) || s1_last_ff);
      lookup.node  = next_node;
      lookup.dead  = (next_node == DEAD_NODE);

      cur_in      = eff_cur;
      muted_in    = eff_muted;
      s1_valid_in = 1'b0;
      s1_live_in  = s1_live_ff;
      s1_last_in  = s1_last_ff;
      if (req_fire) begin
         case (req_payload.opcode)
            OP_RESTART: begin
               cur_in   = start_state;
               muted_in = 1'b0;
            end
            OP_DATA: begin
               if (eff_muted) begin
                  muted_in = !req_payload.last;
               end else begin
                  s1_valid_in = 1'b1;
                  s1_live_in  = (eff_cur != DEAD_NODE);
                  s1_last_in  = req_payload.last;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= DEAD_NODE;
         muted_ff    <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         cur_ff      <= cur_in;
         muted_ff    <= muted_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_live_ff <= s1_live_in;
      s1_last_ff <= s1_last_in;
   end

   a_mute_means_dead: assert property (@(posedge clock) disable iff (reset)
      muted_ff |-> (cur_ff == DEAD_NODE))
      else $error("chunk is muted while the current node is live");

   a_lookup_has_request: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> $past(req_fire))
      else $error("byte lookup without an accepted request");

endmodule

### hw/rtl/dfabm_resolve.sv
// Node flag and tag stores, result formation and the result queue.
module dfabm_resolve (
   input  logic                  clock,
   input  logic                  reset,
   input  dfabm_pkg::clear_type  clear,
   input  logic                  req_fire,
   input  dfabm_pkg::req_type    req_payload,
   input  dfabm_pkg::lookup_type lookup,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dfabm_pkg::rsp_type    rsp_payload
);
   import dfabm_pkg::*;

   logic                  node_we;
   logic                  flag_we;
   node_type              flag_waddr;
   logic                  flag_wdata;
   logic                  flag_rdata;
   tag_type               tag_rdata;
   logic                  s2_valid_ff;
   logic                  s2_dead_ff;
   logic                  push;
   logic                  pop;
   rsp_type               push_data;
   rsp_type               queue_ff [QUEUE_DEPTH];
   logic [QUEUE_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] pending;

   assign node_we = req_fire && (req_payload.opcode == OP_WRITE_NODE)
                    && (req_payload.node != DEAD_NODE);

   always_comb begin
      if (clear.busy) begin
         flag_we    = 1'b1;
         flag_waddr = clear.addr[NODE_BITS-1:0];
         flag_wdata = 1'b0;
      end else begin
         flag_we    = node_we;
         flag_waddr = req_payload.node;
         flag_wdata = req_payload.accepting;
      end
   end

   dfabm_ram #(
      .WIDTH (1),
      .DEPTH (NODE_COUNT)
   ) u_flag_ram (
      .clock (clock),
      .we    (flag_we),
      .waddr (flag_waddr),
      .wdata (flag_wdata),
      .raddr (lookup.node),
      .rdata (flag_rdata)
   );

   dfabm_ram #(
      .WIDTH (TAG_BITS),
      .DEPTH (NODE_COUNT)
   ) u_tag_ram (
      .clock (clock),
      .we    (node_we),
      .waddr (req_payload.node),
      .wdata (req_payload.tag),
      .raddr (lookup.node),
      .rdata (tag_rdata)
   );

   always_comb begin
      push = s2_valid_ff;
      pop  = rsp_valid && rsp_ready;
      if (s2_dead_ff) begin
         push_data.status = ST_REJECT;
      end else if (flag_rdata) begin
         push_data.status = ST_ACCEPT;
      end else begin
         push_data.status = ST_MORE;
      end
      push_data.match_tag = (push_data.status == ST_ACCEPT) ? tag_rdata : '0;

      wr_ptr_in = push ? wr_ptr_ff + QUEUE_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + COUNT_BITS'(push) - COUNT_BITS'(pop);

      // Results already promised: queued, being formed, or just looked up.
      pending = count_ff + COUNT_BITS'(s2_valid_ff) + COUNT_BITS'(lookup.valid);
      room    = (pending < COUNT_BITS'(QUEUE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         s2_valid_ff <= lookup.valid;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_dead_ff <= lookup.dead;
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_payload = queue_ff[rd_ptr_ff];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && (count_ff == COUNT_BITS'(QUEUE_DEPTH))))
      else $error("result queue overflow");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("result queue count out of range");

endmodule
